FILE: hw/rtl/utfed_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UTF encoding detector.
// No dependencies.
package utfed_pkg;

	// UTF-8 automaton state codes
	localparam logic [3:0] EXP_LEAD  = 4'd0;
	localparam logic [3:0] EXP_CONT1 = 4'd1;
	localparam logic [3:0] EXP_CONT2 = 4'd2;
	localparam logic [3:0] EXP_CONT3 = 4'd3;
	localparam logic [3:0] EXP_E0    = 4'd4;
	localparam logic [3:0] EXP_ED    = 4'd5;
	localparam logic [3:0] EXP_F0    = 4'd6;
	localparam logic [3:0] EXP_F4    = 4'd7;

	localparam logic [7:0]  CONT_LO   = 8'h80;
	localparam logic [7:0]  CONT_HI   = 8'hBF;
	localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
	localparam logic [5:0]  SURR_HIGH = 6'b110110;
	localparam logic [5:0]  SURR_LOW  = 6'b110111;
	localparam logic [4:0]  SURR_TAG  = 5'b11011;

	// one request retiring from the input stage
	typedef struct packed {
		logic       take;
		logic       has;
		logic       last;
		logic [7:0] data;
	} step_t;

endpackage

FILE: hw/rtl/utf_encoding_detector.sv
`timescale 1ns / 1ps
// Top level of the UTF encoding detector: input register, validators, result register.
// Depends on utfed_pkg, utfed_utf8_chk, utfed_word_chk.
//
//  channel | dir | tdata                         | tuser    | tlast
//  s_      | in  | [7:0] data_byte               | has_byte | last_item
//  m_      | out | [0] utf8_valid [1] utf16le_valid [2] utf32le_valid, [7:3] zero | - | -
//
// One byte per cycle sustained while no last request is held back; a request is held in the input register,
// and the verdict appears in the result register the cycle after the last request leaves it.
// Reset clears both valid flags and all validator state; held bytes are not reset.
// Validator state is updated as a request leaves the input register.
// A non-last request never waits on m_tready; a last request waits only while
// an earlier verdict is still unaccepted.
module utf_encoding_detector import utfed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] has_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] utf8, [1] utf16le, [2] utf32le, rest zero
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       has_s1;
	logic       last_s1;
	logic       out_free;
	logic       adv;
	step_t      step;
	logic       v8, v16, v32;
	logic       out_valid_q;
	logic [2:0] out_flags_q;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			has_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	assign step = '{take: adv, has: has_s1, last: last_s1, data: data_s1};

	utfed_utf8_chk u_utf8 (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.verdict (v8)
	);

	utfed_word_chk u_word (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.verdict16 (v16),
		.verdict32 (v32)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_flags_q <= {v32, v16, v8};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_flags_q};

	a_last_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> m_tvalid)
		else $error("last request retired without a verdict");

	a_last_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && m_tvalid && !m_tready) |=> (valid_s1 && $stable(last_s1)))
		else $error("last request left input stage while verdict was blocked");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && m_tvalid))
		else $error("input stalled without a blocked last request");

	a_result_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("verdict dropped without being taken");

endmodule

FILE: hw/rtl/utfed_utf8_chk.sv
`timescale 1ns / 1ps
// UTF-8 well-formedness automaton, one byte per step.
// Depends on utfed_pkg.
module utfed_utf8_chk import utfed_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  step_t step,
	output logic  verdict
);

	logic [3:0] expect_q, expect_n;
	logic       good_q, good_n;
	logic [7:0] b, lo, hi;
	logic [3:0] nxt;
	logic       cont_st;

	assign b = step.data;

	always_comb begin
		expect_n = expect_q;
		good_n   = good_q;
		lo       = CONT_LO;
		hi       = CONT_HI;
		nxt      = EXP_LEAD;
		cont_st  = 1'b1;
		unique case (expect_q)
			EXP_LEAD:  cont_st = 1'b0;
			EXP_CONT1: nxt = EXP_LEAD;
			EXP_CONT2: nxt = EXP_CONT1;
			EXP_CONT3: nxt = EXP_CONT2;
			EXP_E0: begin
				lo  = 8'hA0;
				nxt = EXP_CONT1;
			end
			EXP_ED: begin
				hi  = 8'h9F;
				nxt = EXP_CONT1;
			end
			EXP_F0: begin
				lo  = 8'h90;
				nxt = EXP_CONT2;
			end
			EXP_F4: begin
				hi  = 8'h8F;
				nxt = EXP_CONT2;
			end
			default: begin
				lo  = 8'hFF;
				hi  = 8'h00;
			end
		endcase
		if (step.has) begin
			if (!cont_st) begin
				priority if (b <= 8'h7F) begin
					expect_n = EXP_LEAD;
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					expect_n = EXP_CONT1;
				end else if (b == 8'hE0) begin
					expect_n = EXP_E0;
				end else if (b == 8'hED) begin
					expect_n = EXP_ED;
				end else if (b >= 8'hE1 && b <= 8'hEF) begin
					expect_n = EXP_CONT2;
				end else if (b == 8'hF0) begin
					expect_n = EXP_F0;
				end else if (b >= 8'hF1 && b <= 8'hF3) begin
					expect_n = EXP_CONT3;
				end else if (b == 8'hF4) begin
					expect_n = EXP_F4;
				end else begin
					good_n   = 1'b0;
					expect_n = EXP_LEAD;
				end
			end else if (b >= lo && b <= hi) begin
				expect_n = nxt;
			end else begin
				good_n   = 1'b0;
				expect_n = EXP_LEAD;
			end
		end
	end

	assign verdict = good_n && (expect_n == EXP_LEAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= EXP_LEAD;
			good_q   <= 1'b1;
		end else if (step.take) begin
			if (step.last) begin
				expect_q <= EXP_LEAD;
				good_q   <= 1'b1;
			end else begin
				expect_q <= expect_n;
				good_q   <= good_n;
			end
		end
	end

endmodule

FILE: hw/rtl/utfed_word_chk.sv
`timescale 1ns / 1ps
// UTF-16LE surrogate pairing and UTF-32LE range check on assembled words.
// Depends on utfed_pkg.
module utfed_word_chk import utfed_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  step_t step,
	output logic  verdict16,
	output logic  verdict32
);

	logic [1:0]  pos_q, pos_n;
	logic [23:0] held_q, held_n;
	logic        hs_q, hs_n;
	logic        g16_q, g16_n;
	logic        g32_q, g32_n;
	logic [15:0] w16;
	logic [31:0] w32;
	logic        is_hi, is_lo;

	assign w16   = {step.data, (pos_q[1] ? held_q[23:16] : held_q[7:0])};
	assign w32   = {step.data, held_q};
	assign is_hi = (w16[15:10] == SURR_HIGH);
	assign is_lo = (w16[15:10] == SURR_LOW);

	always_comb begin
		pos_n  = pos_q;
		held_n = held_q;
		hs_n   = hs_q;
		g16_n  = g16_q;
		g32_n  = g32_q;
		if (step.has) begin
			pos_n = pos_q + 2'd1;
			unique case (pos_q)
				2'd0: held_n = {16'h0000, step.data};
				2'd1: held_n = {8'h00, step.data, held_q[7:0]};
				2'd2: held_n = {step.data, held_q[15:0]};
				default: held_n = '0;
			endcase
			if (pos_q[0]) begin
				if (hs_q) begin
					hs_n = 1'b0;
					if (!is_lo) begin
						g16_n = 1'b0;
					end
				end else if (is_hi) begin
					hs_n = 1'b1;
				end else if (is_lo) begin
					g16_n = 1'b0;
				end
			end
			if (pos_q == 2'd3) begin
				if (w32 > CP_MAX || w32[31:11] == {16'h0000, SURR_TAG}) begin
					g32_n = 1'b0;
				end
			end
		end
	end

	assign verdict16 = g16_n && !hs_n && !pos_n[0];
	assign verdict32 = g32_n && (pos_n == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			hs_q  <= 1'b0;
			g16_q <= 1'b1;
			g32_q <= 1'b1;
		end else if (step.take) begin
			if (step.last) begin
				pos_q <= 2'd0;
				hs_q  <= 1'b0;
				g16_q <= 1'b1;
				g32_q <= 1'b1;
			end else begin
				pos_q <= pos_n;
				hs_q  <= hs_n;
				g16_q <= g16_n;
				g32_q <= g32_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.take) begin
			held_q <= step.last ? 24'h000000 : held_n;
		end
	end

endmodule
